// ----- src/geo_pkg.sv -----
// Shared types, constants and the arctangent table of the gyro/encoder odometry block.
package geo_pkg;

  localparam int unsigned CNT_W     = 32;
  localparam int unsigned RATE_W    = 28;
  localparam int unsigned DT_W      = 21;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned YAW_W     = 25;
  localparam int unsigned CPC_W     = 24;
  localparam int unsigned CMD_W     = 2;

  localparam int unsigned SUM_W     = 33;
  localparam int unsigned D_W       = 48;
  localparam int unsigned D_LO_W    = 24;
  localparam int unsigned MUL_A_W   = 33;
  localparam int unsigned MUL_B_W   = 25;
  localparam int unsigned PROD_W    = 58;
  localparam int unsigned ACC_W     = 82;
  localparam int unsigned DH_W      = 26;
  localparam int unsigned H_W       = 27;
  localparam int unsigned XY_W      = 33;
  localparam int unsigned STEP_W    = 52;
  localparam int unsigned PSUM_W    = 53;
  localparam int unsigned ATAN_N    = 24;
  localparam int unsigned ATAN_IDX_W = 5;
  localparam int unsigned ATAN_W    = 22;

  localparam logic [CPC_W-1:0] CPC_RESET = 24'd176781;

  localparam logic signed [H_W-1:0] DEG90  = 27'sd5898240;
  localparam logic signed [H_W-1:0] DEG180 = 27'sd11796480;
  localparam logic signed [H_W-1:0] DEG360 = 27'sd23592960;

  // CORDIC gain-compensated start vector, Q30
  localparam logic signed [XY_W-1:0] CORDIC_K = 33'sd652032874;

  localparam logic signed [PROD_W-1:0] DIST_RND = 58'sd256;
  localparam logic signed [PROD_W-1:0] HEAD_RND = 58'sd8388608;
  localparam logic signed [ACC_W-1:0]  ACC_RND  = 82'sd536870912;

  localparam logic signed [PSUM_W-1:0] PSUM_MAX = 53'sd2147483647;
  localparam logic signed [PSUM_W-1:0] PSUM_MIN = -53'sd2147483648;

  // atan(2^-i) in 1/65536 degree
  localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_N] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  typedef enum logic [CMD_W-1:0] {
    CMD_PREDICT  = 2'd0,
    CMD_SET_POSE = 2'd1,
    CMD_INIT     = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_DIFF,
    OP_DIST,
    OP_HEAD,
    OP_FOLD,
    OP_ROT,
    OP_SINCOS,
    OP_ACC_INIT,
    OP_ACC_ADD,
    OP_POS_E,
    OP_POS_N,
    OP_SET_POSE,
    OP_INIT,
    OP_OUT
  } dp_op_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_DIST,
    MUL_YAW,
    MUL_S_LO,
    MUL_S_HI,
    MUL_C_LO,
    MUL_C_HI
  } mul_sel_e;

  typedef struct packed {
    dp_op_e   op;
    mul_sel_e mul;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             rot_last;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_DIFF,
    S_MUL_D,
    S_MUL_H,
    S_HEAD,
    S_FOLD,
    S_ROT,
    S_SINCOS,
    S_E_LO,
    S_E_HI,
    S_E_ACC,
    S_E_POS,
    S_N_HI,
    S_N_ACC,
    S_N_POS,
    S_SET,
    S_INIT,
    S_DONE
  } ctl_state_e;

endpackage

// ----- src/gyro_encoder_odometry.sv -----
// Top level of the gyro/encoder dead-reckoning pose tracker.
// A predict item runs through CORDIC_STEPS rotations of the CORDIC rotator (16 by default),
// which does one rotation per cycle, and six uses of one shared 33x25 multiplier before the
// block can accept again; set-pose and init pass through a state of their own, the unused
// command goes straight to the output. The result sits in an output register;
// the block accepts the next item while it waits there, but holds that item's own result
// until the previous one has been taken. cfg_ready_o is always high; write cm_per_count
// only while the block is idle.
module gyro_encoder_odometry import geo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic signed [CNT_W-1:0]  left_count_i,
  input  logic signed [CNT_W-1:0]  right_count_i,
  input  logic signed [RATE_W-1:0] gyro_rate_i,
  input  logic [DT_W-1:0]          step_time_i,
  input  logic signed [POS_W-1:0]  pose_x_i,
  input  logic signed [POS_W-1:0]  pose_y_i,
  input  logic signed [YAW_W-1:0]  pose_heading_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [POS_W-1:0]  pos_x_o,
  output logic signed [POS_W-1:0]  pos_y_o,
  output logic signed [YAW_W-1:0]  heading_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CPC_W-1:0]         cfg_data_i
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  assign cfg_ready_o = 1'b1;

  geo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  geo_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i_field    (cmd_i),
    .left_count_i   (left_count_i),
    .right_count_i  (right_count_i),
    .gyro_rate_i    (gyro_rate_i),
    .step_time_i    (step_time_i),
    .pose_x_i       (pose_x_i),
    .pose_y_i       (pose_y_i),
    .pose_heading_i (pose_heading_i),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .heading_o      (heading_o)
  );

endmodule

// ----- src/geo_ctrl.sv -----
// Sequencing state machine and output handshake of the odometry block.
module geo_ctrl import geo_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    cmd_o.mul = MUL_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.cmd)
          CMD_PREDICT:  state_d = S_DIFF;
          CMD_SET_POSE: state_d = S_SET;
          CMD_INIT:     state_d = S_INIT;
          default:      state_d = S_DONE;
        endcase
      end
      S_DIFF: begin
        cmd_o.op = OP_DIFF;
        state_d  = S_MUL_D;
      end
      S_MUL_D: begin
        cmd_o.mul = MUL_DIST;
        state_d   = S_MUL_H;
      end
      S_MUL_H: begin
        cmd_o.mul = MUL_YAW;
        cmd_o.op  = OP_DIST;
        state_d   = S_HEAD;
      end
      S_HEAD: begin
        cmd_o.op = OP_HEAD;
        state_d  = S_FOLD;
      end
      S_FOLD: begin
        cmd_o.op = OP_FOLD;
        state_d  = S_ROT;
      end
      S_ROT: begin
        cmd_o.op = OP_ROT;
        if (stat_i.rot_last) begin
          state_d = S_SINCOS;
        end
      end
      S_SINCOS: begin
        cmd_o.op = OP_SINCOS;
        state_d  = S_E_LO;
      end
      S_E_LO: begin
        cmd_o.mul = MUL_S_LO;
        state_d   = S_E_HI;
      end
      S_E_HI: begin
        cmd_o.mul = MUL_S_HI;
        cmd_o.op  = OP_ACC_INIT;
        state_d   = S_E_ACC;
      end
      S_E_ACC: begin
        cmd_o.op = OP_ACC_ADD;
        state_d  = S_E_POS;
      end
      S_E_POS: begin
        cmd_o.op  = OP_POS_E;
        cmd_o.mul = MUL_C_LO;
        state_d   = S_N_HI;
      end
      S_N_HI: begin
        cmd_o.mul = MUL_C_HI;
        cmd_o.op  = OP_ACC_INIT;
        state_d   = S_N_ACC;
      end
      S_N_ACC: begin
        cmd_o.op = OP_ACC_ADD;
        state_d  = S_N_POS;
      end
      S_N_POS: begin
        cmd_o.op = OP_POS_N;
        state_d  = S_DONE;
      end
      S_SET: begin
        cmd_o.op = OP_SET_POSE;
        state_d  = S_DONE;
      end
      S_INIT: begin
        cmd_o.op = OP_INIT;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = (cmd_o.op == OP_OUT) || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
  assign in_stall_o  = (state_q != S_IDLE);

endmodule

// ----- src/geo_datapath.sv -----
// Pose state, shared multiplier, CORDIC rotator and output register of the odometry block.
module geo_datapath import geo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_stat_t                 stat_o,
  input  logic                     cfg_valid_i,
  input  logic [CPC_W-1:0]         cfg_data_i,
  input  logic [CMD_W-1:0]         cmd_i_field,
  input  logic signed [CNT_W-1:0]  left_count_i,
  input  logic signed [CNT_W-1:0]  right_count_i,
  input  logic signed [RATE_W-1:0] gyro_rate_i,
  input  logic [DT_W-1:0]          step_time_i,
  input  logic signed [POS_W-1:0]  pose_x_i,
  input  logic signed [POS_W-1:0]  pose_y_i,
  input  logic signed [YAW_W-1:0]  pose_heading_i,
  output logic signed [POS_W-1:0]  pos_x_o,
  output logic signed [POS_W-1:0]  pos_y_o,
  output logic signed [YAW_W-1:0]  heading_o
);

  localparam int unsigned ITER_W = $clog2(CORDIC_STEPS);

  // architectural state and configuration
  logic [CPC_W-1:0]         cpc_q;
  logic [CNT_W-1:0]         prev_left_q, prev_right_q;
  logic signed [POS_W-1:0]  east_q, north_q;
  logic signed [YAW_W-1:0]  yaw_q;
  logic [ITER_W-1:0]        iter_q;

  // captured item
  logic [CMD_W-1:0]         cmd_q;
  logic [CNT_W-1:0]         left_q, right_q;
  logic signed [RATE_W-1:0] rate_q;
  logic [DT_W-1:0]          dt_q;
  logic signed [POS_W-1:0]  pose_x_q, pose_y_q;
  logic signed [YAW_W-1:0]  pose_h_q;

  // working registers
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [D_W-1:0]    d_q;
  logic signed [XY_W-1:0]   x_q, y_q, s_q, c_q;
  logic signed [H_W-1:0]    z_q;
  logic                     neg_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [POS_W-1:0]  pos_x_q, pos_y_q;
  logic signed [YAW_W-1:0]  heading_q;

  logic [CNT_W-1:0]         dl_w, dr_w;
  logic signed [SUM_W-1:0]  sum_w;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_w, drnd_w, hrnd_w;
  logic signed [DH_W-1:0]   dh_w;
  logic signed [H_W-1:0]    h_w, h_wrap, z0_w, zf_w, at_w;
  logic                     negf_w;
  logic signed [XY_W-1:0]   xs_w, ys_w;
  logic signed [STEP_W-1:0] step_w;
  logic signed [POS_W-1:0]  pos_sel;
  logic signed [PSUM_W-1:0] psum_w;
  logic signed [POS_W-1:0]  psat_w;

  // encoder deltas, wrapping
  assign dl_w  = left_q - prev_left_q;
  assign dr_w  = right_q - prev_right_q;
  assign sum_w = $signed({dl_w[CNT_W-1], dl_w}) + $signed({dr_w[CNT_W-1], dr_w});

  // shared multiplier operand select
  always_comb begin
    case (cmd_i.mul)
      MUL_DIST: begin
        mul_a = sum_q;
        mul_b = $signed({1'b0, cpc_q});
      end
      MUL_YAW: begin
        mul_a = MUL_A_W'(rate_q);
        mul_b = $signed({{(MUL_B_W-DT_W){1'b0}}, dt_q});
      end
      MUL_S_LO: begin
        mul_a = s_q;
        mul_b = $signed({1'b0, d_q[D_LO_W-1:0]});
      end
      MUL_S_HI: begin
        mul_a = s_q;
        mul_b = MUL_B_W'($signed(d_q[D_W-1:D_LO_W]));
      end
      MUL_C_LO: begin
        mul_a = c_q;
        mul_b = $signed({1'b0, d_q[D_LO_W-1:0]});
      end
      MUL_C_HI: begin
        mul_a = c_q;
        mul_b = MUL_B_W'($signed(d_q[D_W-1:D_LO_W]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_w = mul_a * mul_b;

  // distance and heading rounding
  assign drnd_w = prod_q + DIST_RND;
  assign hrnd_w = prod_q + HEAD_RND;
  assign dh_w   = $signed(hrnd_w[DH_W+23:24]);
  assign h_w    = H_W'(yaw_q) + H_W'(dh_w);

  always_comb begin
    if (h_w > DEG180) begin
      h_wrap = h_w - DEG360;
    end else if (h_w < -DEG180) begin
      h_wrap = h_w + DEG360;
    end else begin
      h_wrap = h_w;
    end
  end

  // fold into +-90 degrees before rotation
  assign z0_w = H_W'(yaw_q);
  always_comb begin
    negf_w = 1'b1;
    if (z0_w > DEG90) begin
      zf_w = z0_w - DEG180;
    end else if (z0_w < -DEG90) begin
      zf_w = z0_w + DEG180;
    end else begin
      zf_w   = z0_w;
      negf_w = 1'b0;
    end
  end

  assign xs_w = x_q >>> iter_q;
  assign ys_w = y_q >>> iter_q;
  assign at_w = $signed({{(H_W-ATAN_W){1'b0}}, ATAN_TAB[ATAN_IDX_W'(iter_q)]});

  // position update with saturation
  assign step_w  = acc_q[ACC_W-1:ACC_W-STEP_W];
  assign pos_sel = (cmd_i.op == OP_POS_E) ? east_q : north_q;
  assign psum_w  = PSUM_W'(pos_sel) + PSUM_W'(step_w);

  always_comb begin
    if (psum_w > PSUM_MAX) begin
      psat_w = PSUM_MAX[POS_W-1:0];
    end else if (psum_w < PSUM_MIN) begin
      psat_w = PSUM_MIN[POS_W-1:0];
    end else begin
      psat_w = psum_w[POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpc_q        <= CPC_RESET;
      prev_left_q  <= '0;
      prev_right_q <= '0;
      east_q       <= '0;
      north_q      <= '0;
      yaw_q        <= '0;
      iter_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        cpc_q <= cfg_data_i;
      end
      unique case (cmd_i.op)
        OP_DIFF: begin
          prev_left_q  <= left_q;
          prev_right_q <= right_q;
        end
        OP_HEAD:     yaw_q   <= h_wrap[YAW_W-1:0];
        OP_FOLD:     iter_q  <= '0;
        OP_ROT:      iter_q  <= iter_q + ITER_W'(1);
        OP_POS_E:    east_q  <= psat_w;
        OP_POS_N:    north_q <= psat_w;
        OP_SET_POSE: begin
          east_q  <= pose_x_q;
          north_q <= pose_y_q;
          yaw_q   <= pose_h_q;
        end
        OP_INIT: begin
          prev_left_q  <= left_q;
          prev_right_q <= right_q;
          east_q       <= '0;
          north_q      <= '0;
          yaw_q        <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul != MUL_NONE) begin
      prod_q <= prod_w;
    end
    unique case (cmd_i.op)
      OP_CAPTURE: begin
        cmd_q    <= cmd_i_field;
        left_q   <= left_count_i;
        right_q  <= right_count_i;
        rate_q   <= gyro_rate_i;
        dt_q     <= step_time_i;
        pose_x_q <= pose_x_i;
        pose_y_q <= pose_y_i;
        pose_h_q <= pose_heading_i;
      end
      OP_DIFF:     sum_q <= sum_w;
      OP_DIST:     d_q   <= drnd_w[D_W+8:9];
      OP_FOLD: begin
        x_q   <= CORDIC_K;
        y_q   <= '0;
        z_q   <= zf_w;
        neg_q <= negf_w;
      end
      OP_ROT: begin
        if (!z_q[H_W-1]) begin
          x_q <= x_q - ys_w;
          y_q <= y_q + xs_w;
          z_q <= z_q - at_w;
        end else begin
          x_q <= x_q + ys_w;
          y_q <= y_q - xs_w;
          z_q <= z_q + at_w;
        end
      end
      OP_SINCOS: begin
        s_q <= neg_q ? -y_q : y_q;
        c_q <= neg_q ? -x_q : x_q;
      end
      OP_ACC_INIT: acc_q <= ACC_W'(prod_q) + ACC_RND;
      OP_ACC_ADD:  acc_q <= acc_q + $signed({prod_q, {D_LO_W{1'b0}}});
      OP_OUT: begin
        pos_x_q   <= east_q;
        pos_y_q   <= north_q;
        heading_q <= yaw_q;
      end
      default: ;
    endcase
  end

  assign stat_o.cmd      = cmd_q;
  assign stat_o.rot_last = (iter_q == ITER_W'(CORDIC_STEPS - 1));

  assign pos_x_o   = pos_x_q;
  assign pos_y_o   = pos_y_q;
  assign heading_o = heading_q;

endmodule

// ----- src/geo_checker.sv -----
// Port-level assertions for the odometry block and their bind to the top level.
module geo_checker import geo_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_i,
  input logic                     out_valid_i,
  input logic                     out_stall_i,
  input logic signed [POS_W-1:0]  pos_x_i,
  input logic signed [POS_W-1:0]  pos_y_i,
  input logic signed [YAW_W-1:0]  heading_i
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i)
    else $error("block not busy after accepting an item");

  a_resume_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_i) |-> out_valid_i)
    else $error("input reopened without a result on the output");

  a_result_reopens_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !in_stall_i)
    else $error("new result while input still stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(pos_x_i) && $stable(pos_y_i)
      && $stable(heading_i))
    else $error("stalled result item changed");

endmodule

bind gyro_encoder_odometry geo_checker u_geo_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .pos_x_i     (pos_x_o),
  .pos_y_i     (pos_y_o),
  .heading_i   (heading_o)
);

// ----- bench/tb_gyro_encoder_odometry.sv -----
// Self-checking testbench for the gyro/encoder dead-reckoning pose tracker.
`timescale 1ns / 1ps

module tb_gyro_encoder_odometry import geo_pkg::*;;

  localparam int unsigned ROT_STEPS      = 16;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_N        = 7;

  localparam logic [CMD_W-1:0]         CMD_UNUSED = 2'd3;
  localparam logic signed [POS_W-1:0]  POS_MAX    = 32'sh7FFFFFFF;
  localparam logic signed [POS_W-1:0]  POS_MIN    = 32'sh80000000;
  localparam logic signed [RATE_W-1:0] RATE_MAX   = 28'sd131072000;
  localparam logic signed [RATE_W-1:0] RATE_MIN   = -28'sd131072000;
  localparam logic [DT_W-1:0]          DT_MAX     = 21'd1677721;
  localparam logic signed [YAW_W-1:0]  YAW_MAX    = 25'sd11796480;
  localparam logic signed [YAW_W-1:0]  YAW_MIN    = -25'sd11796480;
  localparam logic signed [YAW_W-1:0]  YAW_90     = 25'sd5898240;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [CNT_W-1:0]         left;
    logic [CNT_W-1:0]         right;
    logic signed [RATE_W-1:0] rate;
    logic [DT_W-1:0]          dt;
    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
    logic signed [YAW_W-1:0]  ph;
  } odo_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [YAW_W-1:0] h;
  } pose_t;

  typedef struct packed {
    odo_item_t stim;
    logic      chk;
    pose_t     want;
  } table_row_t;

  localparam int unsigned ROW_N = 21;

  // chk rows carry a pose that is obvious by inspection; others use the predictor
  localparam table_row_t DIRECTED [ROW_N] = '{
    '{'{CMD_UNUSED, 32'd0, 32'd0, 28'sd0, 21'd0, 32'sd0, 32'sd0, 25'sd0},
      1'b1, '{32'sd0, 32'sd0, 25'sd0}},
    '{'{CMD_PREDICT, 32'd0, 32'd0, 28'sd0, 21'd0, 32'sd0, 32'sd0, 25'sd0},
      1'b1, '{32'sd0, 32'sd0, 25'sd0}},
    '{'{CMD_PREDICT, 32'd1000, 32'd1000, 28'sd0, 21'd0, 32'sd0, 32'sd0, 25'sd0},
      1'b0, '{32'sd0, 32'sd0, 25'sd0}},
    '{'{CMD_PREDICT, 32'd1000, 32'd3000, RATE_MAX, DT_MAX, 32'sd0, 32'sd0, 25'sd0},
      1'b0, '{32'sd0, 32'sd0, 25'sd0}},
    '{'{CMD_SET_POSE, 32'd0, 32'd0, 28'sd0, 21'd0, POS_MAX - 32'sd16, POS_MIN + 32'sd16,
        YAW_90}, 1'b1, '{POS_MAX - 32'sd16, POS_MIN + 32'sd16, YAW_90}},
    '{'{CMD_PREDICT, 32'h40000000, 32'h40000000, 28'sd0, 21'd0, 32'sd0, 32'sd0, 25'sd0},
      1'b0, '{32'sd0, 32'sd0, 25'sd0}},
    '{'{CMD_SET_POSE, 32'd0, 32'd0, 28'sd0, 21'd0, 32'sd0, POS_MIN + 32'sd16, YAW_MAX},
      1'b1, '{32'sd0, POS_MIN + 32'sd16, YAW_MAX}},
    '{'{CMD_PREDICT, 32'h7FFFFFFF, 32'h7FFFFFFF, 28'sd0, 21'd0, 32'sd0, 32'sd0, 25'sd0},
      1'b0, '{32'sd0, 32'sd0, 25'sd0}},
    '{'{CMD_PREDICT, 32'h80000000, 32'h80000000, RATE_MAX, DT_MAX, 32'sd0, 32'sd0, 25'sd0},
      1'b0, '{32'sd0, 32'sd0, 25'sd0}},
    '{'{CMD_SET_POSE, 32'd0, 32'd0, 28'sd0, 21'd0, 32'sd0, 32'sd0, YAW_MIN},
      1'b1, '{32'sd0, 32'sd0, YAW_MIN}},
    '{'{CMD_PREDICT, 32'h80000064, 32'h80000032, RATE_MIN, DT_MAX, 32'sd0, 32'sd0, 25'sd0},
      1'b0, '{32'sd0, 32'sd0, 25'sd0}},
    '{'{CMD_SET_POSE, 32'd0, 32'd0, 28'sd0, 21'd0, 32'sd0, 32'sd0, -YAW_90},
      1'b1, '{32'sd0, 32'sd0, -YAW_90}},
    '{'{CMD_PREDICT, 32'h80000258, 32'h80000226, 28'sd0, 21'd0, 32'sd0, 32'sd0, 25'sd0},
      1'b0, '{32'sd0, 32'sd0, 25'sd0}},
    '{'{CMD_INIT, 32'd12345, -32'sd6789, 28'sd0, 21'd0, 32'sd77, 32'sd77, 25'sd77},
      1'b1, '{32'sd0, 32'sd0, 25'sd0}},
    '{'{CMD_PREDICT, 32'd12345, -32'sd6789, 28'sd0, 21'd0, 32'sd0, 32'sd0, 25'sd0},
      1'b1, '{32'sd0, 32'sd0, 25'sd0}},
    '{'{CMD_PREDICT, 32'd7345, -32'sd11789, -28'sd1000000, DT_MAX, 32'sd0, 32'sd0, 25'sd0},
      1'b0, '{32'sd0, 32'sd0, 25'sd0}},
    '{'{CMD_UNUSED, '1, '1, '1, '1, '1, '1, '1},
      1'b0, '{32'sd0, 32'sd0, 25'sd0}},
    '{'{CMD_SET_POSE, 32'd0, 32'd0, 28'sd0, 21'd0, POS_MAX, POS_MAX, 25'sd0},
      1'b1, '{POS_MAX, POS_MAX, 25'sd0}},
    '{'{CMD_SET_POSE, 32'd0, 32'd0, 28'sd0, 21'd0, POS_MIN, POS_MIN, -25'sd1},
      1'b1, '{POS_MIN, POS_MIN, -25'sd1}},
    '{'{CMD_INIT, 32'h80000000, 32'h7FFFFFFF, 28'sd0, 21'd0, 32'sd0, 32'sd0, 25'sd0},
      1'b1, '{32'sd0, 32'sd0, 25'sd0}},
    '{'{CMD_PREDICT, 32'h7FFFFFFF, 32'h80000000, RATE_MAX, 21'd1, 32'sd0, 32'sd0, 25'sd0},
      1'b0, '{32'sd0, 32'sd0, 25'sd0}}
  };

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [CMD_W-1:0]         cmd_i;
  logic signed [CNT_W-1:0]  left_count_i;
  logic signed [CNT_W-1:0]  right_count_i;
  logic signed [RATE_W-1:0] gyro_rate_i;
  logic [DT_W-1:0]          step_time_i;
  logic signed [POS_W-1:0]  pose_x_i;
  logic signed [POS_W-1:0]  pose_y_i;
  logic signed [YAW_W-1:0]  pose_heading_i;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [POS_W-1:0]  pos_x_o;
  logic signed [POS_W-1:0]  pos_y_o;
  logic signed [YAW_W-1:0]  heading_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CPC_W-1:0]         cfg_data_i;

  gyro_encoder_odometry #(
    .CORDIC_STEPS(ROT_STEPS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .left_count_i  (left_count_i),
    .right_count_i (right_count_i),
    .gyro_rate_i   (gyro_rate_i),
    .step_time_i   (step_time_i),
    .pose_x_i      (pose_x_i),
    .pose_y_i      (pose_y_i),
    .pose_heading_i(pose_heading_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .heading_o     (heading_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // predictor state
  logic [CPC_W-1:0]        scale_q;
  logic [CNT_W-1:0]        enc_left_q;
  logic [CNT_W-1:0]        enc_right_q;
  logic signed [POS_W-1:0] east_q;
  logic signed [POS_W-1:0] north_q;
  logic signed [YAW_W-1:0] yaw_q;

  pose_t       pose_q [$];
  int unsigned err_count;
  int unsigned idle_cycles;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  logic [CNT_W-1:0] gen_left;
  logic [CNT_W-1:0] gen_right;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic signed [POS_W-1:0] clamp32(input longint v);
    if (v > longint'(POS_MAX)) return POS_MAX;
    if (v < longint'(POS_MIN)) return POS_MIN;
    return v[POS_W-1:0];
  endfunction

  // round(d * s / 2^30), split so the products stay inside 64 bits
  function automatic longint scale_q30(input longint d, input longint s);
    longint dh, dl, a, b;
    dh = d >>> 20;
    dl = d - dh * 64'sd1048576;
    a = dh * s;
    b = dl * s + 64'sd536870912;
    return (a + (b >>> 20)) >>> 10;
  endfunction

  function automatic void cordic_sincos(input longint ang, output longint sn,
                                        output longint cs);
    longint x, y, z, xs, ys;
    bit     flip;
    x = longint'(CORDIC_K);
    y = 0;
    z = ang;
    flip = 1'b0;
    if (z > longint'(DEG90)) begin
      z -= longint'(DEG180);
      flip = 1'b1;
    end else if (z < -longint'(DEG90)) begin
      z += longint'(DEG180);
      flip = 1'b1;
    end
    for (int i = 0; i < ROT_STEPS && i < ATAN_N; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= longint'(ATAN_TAB[i]);
      end else begin
        x += ys;
        y -= xs;
        z += longint'(ATAN_TAB[i]);
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  function automatic pose_t pose_advance(input odo_item_t it);
    logic [CNT_W-1:0] dlw, drw;
    longint dl, dr, d, dh, h, s, c;
    pose_t  r;
    case (it.cmd)
      CMD_PREDICT: begin
        dlw = it.left - enc_left_q;
        drw = it.right - enc_right_q;
        dl = longint'($signed(dlw));
        dr = longint'($signed(drw));
        enc_left_q = it.left;
        enc_right_q = it.right;
        d = ((dl + dr) * longint'(scale_q) + 64'sd256) >>> 9;
        dh = (longint'(it.rate) * longint'(it.dt) + 64'sd8388608) >>> 24;
        h = longint'(yaw_q) + dh;
        if (h > longint'(DEG180)) h -= longint'(DEG360);
        else if (h < -longint'(DEG180)) h += longint'(DEG360);
        yaw_q = h[YAW_W-1:0];
        cordic_sincos(h, s, c);
        east_q = clamp32(longint'(east_q) + scale_q30(d, s));
        north_q = clamp32(longint'(north_q) + scale_q30(d, c));
      end
      CMD_SET_POSE: begin
        east_q = it.px;
        north_q = it.py;
        yaw_q = it.ph;
      end
      CMD_INIT: begin
        enc_left_q = it.left;
        enc_right_q = it.right;
        east_q = '0;
        north_q = '0;
        yaw_q = '0;
      end
      default: ;
    endcase
    r.x = east_q;
    r.y = north_q;
    r.h = yaw_q;
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] next_count(input logic [CNT_W-1:0] cur);
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 7) return cur + $urandom_range(8000) - 4000;
    if (sel < 9) return cur + $urandom_range(2097152) - 1048576;
    return $urandom;
  endfunction

  function automatic odo_item_t random_item();
    odo_item_t   it;
    int unsigned sel;
    it.left = $urandom;
    it.right = $urandom;
    it.rate = 28'($urandom_range(262144000) - 131072000);
    it.dt = 21'($urandom_range(1677721));
    it.px = $urandom;
    it.py = $urandom;
    it.ph = 25'($urandom_range(23592960) - 11796480);
    sel = $urandom_range(99);
    if (sel < 80) begin
      it.cmd = CMD_PREDICT;
      gen_left = next_count(gen_left);
      gen_right = next_count(gen_right);
      it.left = gen_left;
      it.right = gen_right;
      case ($urandom_range(9))
        0: it.rate = 28'($urandom_range(20000) - 10000);
        1: it.dt = '0;
        2: it.dt = DT_MAX;
        3: it.rate = $urandom_range(1) ? RATE_MAX : RATE_MIN;
        default: ;
      endcase
    end else if (sel < 88) begin
      it.cmd = CMD_SET_POSE;
      if ($urandom_range(1)) begin
        it.px = $urandom_range(33554432) - 16777216;
        it.py = $urandom_range(33554432) - 16777216;
      end
    end else if (sel < 94) begin
      it.cmd = CMD_INIT;
      gen_left = it.left;
      gen_right = it.right;
    end else begin
      it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  // entered and left at a falling edge; payload holds while stalled
  task automatic send_item(input odo_item_t it, input logic chk, input pose_t want);
    pose_t p;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    cmd_i <= it.cmd;
    left_count_i <= it.left;
    right_count_i <= it.right;
    gyro_rate_i <= it.rate;
    step_time_i <= it.dt;
    pose_x_i <= it.px;
    pose_y_i <= it.py;
    pose_heading_i <= it.ph;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    p = pose_advance(it);
    pose_q.push_back(chk ? want : p);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (ROT_STEPS + 16) @(negedge clk_i);
  endtask

  task automatic write_scale(input logic [CPC_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    scale_q = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < snk_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    pose_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pose_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d h=%0d", $time, pos_x_o, pos_y_o,
                 heading_o);
        err_count++;
      end else begin
        want = pose_q.pop_front();
        if (pos_x_o !== want.x) begin
          $display("%0t: pos_x expected %0d got %0d", $time, want.x, pos_x_o);
          err_count++;
        end
        if (pos_y_o !== want.y) begin
          $display("%0t: pos_y expected %0d got %0d", $time, want.y, pos_y_o);
          err_count++;
        end
        if (heading_o !== want.h) begin
          $display("%0t: heading expected %0d got %0d", $time, want.h, heading_o);
          err_count++;
        end
      end
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("gyro_encoder_odometry test failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned n_items;
    logic        do_write;
    logic [CPC_W-1:0] sc;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = CMD_PREDICT;
    left_count_i = '0;
    right_count_i = '0;
    gyro_rate_i = '0;
    step_time_i = '0;
    pose_x_i = '0;
    pose_y_i = '0;
    pose_heading_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    err_count = 0;
    idle_cycles = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    gen_left = '0;
    gen_right = '0;
    scale_q = CPC_RESET;
    enc_left_q = '0;
    enc_right_q = '0;
    east_q = '0;
    north_q = '0;
    yaw_q = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < ROW_N; i++) begin
      send_item(DIRECTED[i].stim, DIRECTED[i].chk, DIRECTED[i].want);
    end
    gen_left = enc_left_q;
    gen_right = enc_right_q;

    for (int ph = 0; ph < PHASE_N; ph++) begin
      do_write = 1'b1;
      case (ph)
        0: begin
          do_write = 1'b0;
          sc = CPC_RESET;
          src_idle_pct = 0;
          snk_stall_pct = 0;
          n_items = 180;
        end
        1: begin
          sc = 24'd1;
          src_idle_pct = 56;
          snk_stall_pct = 0;
          n_items = 150;
        end
        2: begin
          sc = 24'hFFFFFF;
          src_idle_pct = 0;
          snk_stall_pct = 56;
          n_items = 200;
        end
        3: begin
          sc = $urandom_range(24'hFFFFFF, 1);
          src_idle_pct = 37;
          snk_stall_pct = 37;
          n_items = 200;
        end
        4: begin
          sc = '0;
          src_idle_pct = 56;
          snk_stall_pct = 0;
          n_items = 100;
        end
        5: begin
          sc = $urandom_range(400000, 50000);
          src_idle_pct = 0;
          snk_stall_pct = 0;
          n_items = 150;
        end
        default: begin
          sc = CPC_RESET;
          src_idle_pct = 37;
          snk_stall_pct = 37;
          n_items = 200;
        end
      endcase
      if (do_write) begin
        in_valid_i <= 1'b0;
        wait_idle();
        write_scale(sc);
      end
      for (int n = 0; n < n_items; n++) begin
        send_item(random_item(), 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (ROT_STEPS + 16) @(posedge clk_i);
    if (err_count == 0) begin
      $display("gyro_encoder_odometry test passed");
    end else begin
      $display("gyro_encoder_odometry test failed");
    end
    $finish;
  end

endmodule

// ----- gyro_encoder_odometry.f -----
src/geo_pkg.sv
src/geo_ctrl.sv
src/geo_datapath.sv
src/gyro_encoder_odometry.sv
src/geo_checker.sv
bench/tb_gyro_encoder_odometry.sv
